/* design/fspa_pkg.sv */
// ----------------------------------------------------------------------------
// fspa_pkg: shared types and constants of the fixed slot pool allocator
// Payload structs, request/status codes, register indexes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fspa_pkg;

	localparam int unsigned SLOTS_DEF = 1024;

	localparam int unsigned ADDR_W     = 48;
	localparam int unsigned SIZE_CFG_W = 13;
	localparam int unsigned CNT_CFG_W  = 11;
	localparam int unsigned ESIZE_W    = 14;   // rounded slot size, up to 8192
	localparam int unsigned CNT_W      = 32;   // internal in-use / peak counters
	localparam int unsigned OUT_CNT_W  = 11;
	localparam int unsigned CFG_IDX_W  = 2;

	// request types
	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_RESET = 2'd2;
	localparam logic [1:0] REQ_QUERY = 2'd3;

	// result status
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_NOT_OWNED = 2'd2;
	localparam logic [1:0] ST_NULL_FREE = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

	localparam logic [ADDR_W-1:0]     BASE_RST  = 48'd4096;
	localparam logic [SIZE_CFG_W-1:0] SIZE_RST  = 13'd32;
	localparam logic [CNT_CFG_W-1:0]  COUNT_RST = 11'd1024;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]    slot_address;
		logic [1:0]           status;
		logic                 owned;
		logic [OUT_CNT_W-1:0] in_use;
		logic [OUT_CNT_W-1:0] peak_in_use;
		logic [OUT_CNT_W-1:0] free_count;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic       take_req;
		logic       mem_rd;
		logic       pop;
		logic       take_fresh;
		logic       mul_addr;
		logic       add_addr;
		logic       chk_start;
		logic       div_start;
		logic       push;
		logic       set_owned;
		logic       set_status;
		logic [1:0] status_code;
		logic       reset_all;
		logic       finish;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] req_type;
		logic       list_nonempty;
		logic       fresh_avail;
		logic       addr_null;
		logic       in_range;
		logic       div_done;
		logic       rem_zero;
		logic       out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

/* design/fspa_req_if.sv */
// ----------------------------------------------------------------------------
// fspa_req_if: request channel
// valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface fspa_req_if;
	import fspa_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/fspa_rsp_if.sv */
// ----------------------------------------------------------------------------
// fspa_rsp_if: result channel
// valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface fspa_rsp_if;
	import fspa_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/fixed_slot_pool_allocator_top.sv */
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator_top: fixed-size slot pool allocator
// Hands out equal slots of a pool, freed ones first from a LIFO free list;
// frees, resets, answers ownership queries; one result item per request item.
// ----------------------------------------------------------------------------
// Usage:
//  - req: request items (req_type, address), taken when valid & ready.
//  - rsp: one result item per request, in order, held until ready.
//  - cfg_we/cfg_index/cfg_data: write base address (0), slot size (1) and
//    slot count (2); write only while no request is in flight.
//  - Steps per item: allocate pops the free list or takes a fresh slot, then
//    multiplies and adds the address (exhausted goes straight to the result);
//    reset and null free go straight to the result; free/query checks the
//    range and, if in range, runs the ownership divider (QW-bit quotient,
//    QW = clog2(min(SLOTS, 2047))), one quotient bit per cycle. The next
//    request can be accepted in the cycle after the result is loaded.
//  - The result sits in an output register: a new request is accepted while
//    the previous result waits; a stalled receiver only holds the block at
//    the end of the next request, until the output register frees up.
//  - Reset: config takes its reset values, free list empty, all counters
//    zero, no result pending. The link memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_slot_pool_allocator_top #(
	parameter int unsigned SLOTS = fspa_pkg::SLOTS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [fspa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fspa_pkg::ADDR_W-1:0]    cfg_data,
	fspa_req_if.sink                            req,
	fspa_rsp_if.source                          rsp
);
	import fspa_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: one request at a time
	fspa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage, arithmetic, divider and output register
	fspa_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (req.data),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (rsp.valid),
		.out_data  (rsp.data)
	);
endmodule

`default_nettype wire

/* design/fspa_div.sv */
// ----------------------------------------------------------------------------
// fspa_div: iterative divider
// Restoring division, one quotient bit per cycle, MSB first. The quotient is
// known to fit QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fspa_div #(
	parameter int unsigned QW  = 10,
	parameter int unsigned DW  = 19,
	parameter int unsigned DVW = 10
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [DW-1:0]  dividend,
	input  wire logic [DVW-1:0] divisor,
	output logic                done,
	output logic [QW-1:0]       quotient,
	output logic                rem_zero
);
	localparam int unsigned SW = (QW > 1) ? $clog2(QW) : 1;

	logic [DW-1:0]  rem_q;
	logic [DVW-1:0] dvs_q;
	logic [QW-1:0]  quo_q;
	logic [SW-1:0]  step_q;
	logic           busy_q;
	logic           done_q;
	logic [DW-1:0]  trial;
	logic           ge;

	assign trial = DW'(dvs_q) << step_q;
	assign ge    = (rem_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SW'(QW - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q && ge) begin
			rem_q         <= rem_q - trial;
			quo_q[step_q] <= 1'b1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
	assign rem_zero = (rem_q == '0);
endmodule

`default_nettype wire

/* design/fspa_dp.sv */
// ----------------------------------------------------------------------------
// fspa_dp: allocator datapath
// Config registers, free-list link memory, head/fresh/in-use/peak counters,
// address multiply, ownership check with divider, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fspa_dp #(
	parameter int unsigned SLOTS = fspa_pkg::SLOTS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [fspa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fspa_pkg::ADDR_W-1:0]      cfg_data,
	input  wire fspa_pkg::req_t                   in_data,
	input  wire logic                             out_ready,
	input  wire fspa_pkg::dp_cmd_t                cmd,
	output fspa_pkg::dp_sts_t                     sts,
	output logic                                  out_valid,
	output fspa_pkg::rsp_t                        out_data
);
	import fspa_pkg::*;

	localparam int unsigned IW      = $clog2(SLOTS);
	localparam int unsigned CNT_MAX = (SLOTS < 2047) ? SLOTS : 2047;
	localparam int unsigned CW      = $clog2(CNT_MAX + 1);
	localparam int unsigned QW      = $clog2(CNT_MAX);
	localparam int unsigned DVW     = ESIZE_W - 4;
	localparam int unsigned DW      = QW + DVW - 1;
	localparam int unsigned PW      = IW + ESIZE_W;
	localparam int unsigned LW      = ESIZE_W + CW;

	// config
	logic [ADDR_W-1:0]     base_q;
	logic [SIZE_CFG_W-1:0] size_cfg_q;
	logic [CNT_CFG_W-1:0]  count_cfg_q;

	// allocator state
	logic [IW-1:0]    link_mem [SLOTS];
	logic [IW-1:0]    link_rd_q;
	logic [IW-1:0]    head_q;
	logic             nonempty_q;
	logic [IW:0]      fresh_q;
	logic [CNT_W-1:0] in_use_q;
	logic [CNT_W-1:0] peak_q;

	// per-request work registers
	req_t              req_q;
	logic [IW-1:0]     idx_q;
	logic [PW-1:0]     prod_q;
	logic [ADDR_W-1:0] off_q;
	logic              below_q;
	logic [LW-1:0]     lim_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [1:0]        res_status_q;
	logic              res_owned_q;
	rsp_t              out_q;
	logic              out_valid_q;

	logic [ESIZE_W-1:0] esize_r;
	logic [ESIZE_W-1:0] esize;
	logic [CW-1:0]      cnt;
	logic [CNT_W-1:0]   cnt_ext;
	logic [CNT_W-1:0]   free_full;
	logic [CNT_W-1:0]   in_use_inc;
	logic               div_done;
	logic [QW-1:0]      div_quo;
	logic               div_rem_zero;
	logic [IW-1:0]      push_idx;

	// slot size rounded up to 16, zero taken as 16
	assign esize_r = (ESIZE_W'(size_cfg_q) + ESIZE_W'(15)) & ~ESIZE_W'(15);
	assign esize   = (esize_r == '0) ? ESIZE_W'(16) : esize_r;
	assign cnt     = (32'(count_cfg_q) > 32'(SLOTS)) ? CW'(SLOTS) : CW'(count_cfg_q);
	assign cnt_ext = CNT_W'(cnt);
	assign free_full  = (cnt_ext > in_use_q) ? (cnt_ext - in_use_q) : '0;
	assign in_use_inc = in_use_q + 1'b1;
	assign push_idx   = IW'(div_quo);

	fspa_div #(
		.QW  (QW),
		.DW  (DW),
		.DVW (DVW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (off_q[DW+3:4]),
		.divisor  (esize[ESIZE_W-1:4]),
		.done     (div_done),
		.quotient (div_quo),
		.rem_zero (div_rem_zero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= BASE_RST;
			size_cfg_q  <= SIZE_RST;
			count_cfg_q <= COUNT_RST;
			head_q      <= '0;
			nonempty_q  <= 1'b0;
			fresh_q     <= '0;
			in_use_q    <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BASE:  base_q      <= cfg_data;
					CFG_SIZE:  size_cfg_q  <= cfg_data[SIZE_CFG_W-1:0];
					CFG_COUNT: count_cfg_q <= cfg_data[CNT_CFG_W-1:0];
					default: ;
				endcase
			end
			if (cmd.pop) begin
				// a self link ends the list
				if (link_rd_q == head_q) begin
					nonempty_q <= 1'b0;
				end else begin
					head_q <= link_rd_q;
				end
			end
			if (cmd.take_fresh) begin
				fresh_q <= fresh_q + 1'b1;
			end
			if (cmd.add_addr) begin
				in_use_q <= in_use_inc;
				if (in_use_inc > peak_q) begin
					peak_q <= in_use_inc;
				end
			end
			if (cmd.push) begin
				head_q     <= push_idx;
				nonempty_q <= 1'b1;
				if (in_use_q != '0) begin
					in_use_q <= in_use_q - 1'b1;
				end
			end
			if (cmd.reset_all) begin
				head_q     <= '0;
				nonempty_q <= 1'b0;
				fresh_q    <= '0;
				in_use_q   <= '0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// link memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			link_mem[push_idx] <= nonempty_q ? head_q : push_idx;
		end
		if (cmd.mem_rd) begin
			link_rd_q <= link_mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_req) begin
			req_q        <= in_data;
			res_addr_q   <= '0;
			res_status_q <= ST_DONE;
			res_owned_q  <= 1'b0;
		end
		if (cmd.pop) begin
			idx_q <= head_q;
		end
		if (cmd.take_fresh) begin
			idx_q <= fresh_q[IW-1:0];
		end
		if (cmd.mul_addr) begin
			prod_q <= PW'(idx_q) * PW'(esize);
		end
		if (cmd.add_addr) begin
			res_addr_q  <= base_q + ADDR_W'(prod_q);
			res_owned_q <= 1'b1;
		end
		if (cmd.chk_start) begin
			off_q   <= req_q.address - base_q;
			below_q <= (req_q.address < base_q);
			lim_q   <= LW'(esize) * LW'(cnt);
		end
		if (cmd.set_owned) begin
			res_owned_q <= 1'b1;
		end
		if (cmd.set_status) begin
			res_status_q <= cmd.status_code;
		end
		if (cmd.finish) begin
			out_q.slot_address <= res_addr_q;
			out_q.status       <= res_status_q;
			out_q.owned        <= res_owned_q;
			out_q.in_use       <= in_use_q[OUT_CNT_W-1:0];
			out_q.peak_in_use  <= peak_q[OUT_CNT_W-1:0];
			out_q.free_count   <= free_full[OUT_CNT_W-1:0];
		end
	end

	always_comb begin
		sts.req_type      = req_q.req_type;
		sts.list_nonempty = nonempty_q;
		sts.fresh_avail   = (32'(fresh_q) < 32'(cnt));
		sts.addr_null     = (req_q.address == '0);
		sts.in_range      = !below_q && (off_q < ADDR_W'(lim_q)) && (off_q[3:0] == 4'd0);
		sts.div_done      = div_done;
		sts.rem_zero      = div_rem_zero;
		sts.out_free      = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

`default_nettype wire

/* design/fspa_ctrl.sv */
// ----------------------------------------------------------------------------
// fspa_ctrl: allocator controller
// Sequences one request at a time through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fspa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire fspa_pkg::dp_sts_t sts,
	output fspa_pkg::dp_cmd_t      cmd
);
	import fspa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_POP,
		S_MUL,
		S_ADD,
		S_RANGE,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.take_req = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.req_type)
					REQ_ALLOC: begin
						if (sts.list_nonempty) begin
							cmd.mem_rd = 1'b1;
							state_d    = S_POP;
						end else if (sts.fresh_avail) begin
							cmd.take_fresh = 1'b1;
							state_d        = S_MUL;
						end else begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_EXHAUSTED;
							state_d         = S_DONE;
						end
					end
					REQ_FREE: begin
						if (sts.addr_null) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_NULL_FREE;
							state_d         = S_DONE;
						end else begin
							cmd.chk_start = 1'b1;
							state_d       = S_RANGE;
						end
					end
					REQ_RESET: begin
						cmd.reset_all = 1'b1;
						state_d       = S_DONE;
					end
					REQ_QUERY: begin
						cmd.chk_start = 1'b1;
						state_d       = S_RANGE;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul_addr = 1'b1;
				state_d      = S_ADD;
			end
			S_ADD: begin
				cmd.add_addr = 1'b1;
				state_d      = S_DONE;
			end
			S_RANGE: begin
				if (sts.in_range) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					if (sts.req_type == REQ_FREE) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_NOT_OWNED;
					end
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					if (sts.rem_zero) begin
						cmd.set_owned = 1'b1;
						cmd.push      = (sts.req_type == REQ_FREE);
					end else if (sts.req_type == REQ_FREE) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_NOT_OWNED;
					end
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);
endmodule

`default_nettype wire

/* tb/fixed_slot_pool_allocator_top_tb.sv */
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator_top_tb: self-checking bench of the slot pool
// A queue-fed driver sends request items with random gaps. A monitor predicts
// each accepted item with a shadow pool: free-list links, fresh mark and the
// in-use and peak counts. The result channel stalls at random. Every result
// item is checked field by field, in order. Pool settings change between
// phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_slot_pool_allocator_top_tb;
	import fspa_pkg::*;

	localparam int unsigned SLOTS       = SLOTS_DEF;
	localparam int unsigned IDX_W       = $clog2(SLOTS);
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned PHASES      = 10;
	localparam int unsigned PHASE_ITEMS = 95;

	// ------------------------------------------------------------------------
	// clock, reset, DUT
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	initial begin
		forever #2 clk = ~clk;
	end

	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = CFG_BASE;
	logic [ADDR_W-1:0]       cfg_data = '0;

	// bench-side copies of the handshake signals; each has one driver process
	logic req_valid = 1'b0;
	req_t req_data = '0;
	logic rsp_ready = 1'b0;

	fspa_req_if req_ch ();
	fspa_rsp_if rsp_ch ();

	assign req_ch.valid = req_valid;
	assign req_ch.data  = req_data;
	assign rsp_ch.ready = rsp_ready;

	fixed_slot_pool_allocator_top #(
		.SLOTS(SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// ------------------------------------------------------------------------
	// shadow pool: configuration and state, reset values as after arst_n
	// ------------------------------------------------------------------------
	logic [ADDR_W-1:0]     pool_base  = BASE_RST;
	logic [SIZE_CFG_W-1:0] pool_size  = SIZE_RST;
	logic [CNT_CFG_W-1:0]  pool_count = COUNT_RST;

	logic [IDX_W-1:0] link_mem [0:SLOTS-1];
	logic [IDX_W-1:0] list_head  = '0;
	bit               list_live  = 1'b0;
	int unsigned      fresh_next = 0;
	int unsigned      in_use_ct  = 0;   // wide on purpose: double frees can overrun
	int unsigned      peak_ct    = 0;

	// slot addresses currently handed out, used to build well-formed frees
	logic [ADDR_W-1:0] live_slots [$];

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];

	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;
	bit          calm_phase  = 1'b0;    // no gaps and no stalls while set

	// rounded slot size: multiple of 16, zero counts as 16
	function automatic logic [63:0] slot_bytes();
		logic [63:0] s;
		s = ({51'd0, pool_size} + 64'd15) & ~64'd15;
		return (s == 0) ? 64'd16 : s;
	endfunction

	function automatic int unsigned pool_slots();
		return (pool_count > SLOTS) ? SLOTS : int'(pool_count);
	endfunction

	// address of slot k, wrapped to 48 bits
	function automatic logic [ADDR_W-1:0] slot_at(input int unsigned k);
		logic [63:0] a;
		a = pool_base + k * slot_bytes();
		return a[ADDR_W-1:0];
	endfunction

	// aligned slot start inside the unwrapped pool range
	function automatic bit slot_of(input logic [ADDR_W-1:0] addr,
			output logic [IDX_W-1:0] idx);
		logic [63:0] off;
		logic [63:0] sz;
		logic [63:0] q;
		idx = '0;
		sz = slot_bytes();
		if (addr < pool_base)
			return 1'b0;
		off = addr - pool_base;
		if (off >= sz * pool_slots())
			return 1'b0;
		if (off % sz != 0)
			return 1'b0;
		q = off / sz;
		idx = q[IDX_W-1:0];
		return 1'b1;
	endfunction

	// advance the shadow pool by one request item, return its result item
	function automatic rsp_t pool_step(input req_t item);
		rsp_t res;
		logic [IDX_W-1:0] idx;
		int unsigned cnt;
		bit got;
		logic [63:0] full;
		res = '0;
		res.status = ST_DONE;
		idx = '0;
		got = 1'b0;
		cnt = pool_slots();
		case (item.req_type)
			REQ_ALLOC: begin
				if (list_live) begin
					idx = list_head;
					// a self link marks the tail of the free list
					if (link_mem[idx] == idx)
						list_live = 1'b0;
					else
						list_head = link_mem[idx];
					got = 1'b1;
				end else if (fresh_next < cnt) begin
					idx = fresh_next[IDX_W-1:0];
					fresh_next++;
					got = 1'b1;
				end
				if (got) begin
					full = pool_base + idx * slot_bytes();
					res.slot_address = full[ADDR_W-1:0];
					res.owned = 1'b1;
					in_use_ct++;
					if (in_use_ct > peak_ct)
						peak_ct = in_use_ct;
					live_slots.push_back(full[ADDR_W-1:0]);
				end else begin
					res.status = ST_EXHAUSTED;
				end
			end
			REQ_FREE: begin
				// null is checked before ownership, so base zero slot zero is null
				if (item.address == '0) begin
					res.status = ST_NULL_FREE;
				end else if (!slot_of(item.address, idx)) begin
					res.status = ST_NOT_OWNED;
				end else begin
					link_mem[idx] = list_live ? list_head : idx;
					list_head = idx;
					list_live = 1'b1;
					if (in_use_ct > 0)
						in_use_ct--;
					res.owned = 1'b1;
					for (int i = 0; i < live_slots.size(); i++) begin
						if (live_slots[i] == item.address) begin
							live_slots.delete(i);
							break;
						end
					end
				end
			end
			REQ_RESET: begin
				// peak survives a reset of the pool
				list_live = 1'b0;
				list_head = '0;
				fresh_next = 0;
				in_use_ct = 0;
				live_slots.delete();
			end
			default: begin
				res.owned = slot_of(item.address, idx);
			end
		endcase
		res.in_use = in_use_ct[OUT_CNT_W-1:0];
		res.peak_in_use = peak_ct[OUT_CNT_W-1:0];
		full = (cnt > in_use_ct) ? 64'(cnt - in_use_ct) : 64'd0;
		res.free_count = full[OUT_CNT_W-1:0];
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// idling: mostly short gaps, now and then a long one
	// ------------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		if (r < 93)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------------
	// request driver: inputs change at the falling edge
	// ------------------------------------------------------------------------
	bit req_taken = 1'b0;
	int req_gap = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				if (req_gap > 0) begin
					req_valid <= 1'b0;
					req_gap <= req_gap - 1;
				end else if (pending_reqs.size() > 0) begin
					req_data <= pending_reqs.pop_front();
					req_valid <= 1'b1;
					req_gap <= (calm_phase || $urandom_range(0, 99) < 50) ? 0 : pick_gap();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: random stalls
	int rsp_stall = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_stall > 0) begin
				rsp_ready <= 1'b0;
				rsp_stall <= rsp_stall - 1;
			end else begin
				rsp_ready <= 1'b1;
				if (!calm_phase && $urandom_range(0, 99) < 20)
					rsp_stall <= pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: sample at the rising edge, predict accepted requests, check
	// results against the oldest expectation
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	rsp_t want_rsp;

	always @(posedge clk) begin
		req_taken <= req_ch.valid && req_ch.ready;
		if (arst_n) begin
			// results first, so a fresh prediction never pairs with a stray item
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					$display("%0t unexpected result item: expected none, actual %h",
						$time, rsp_ch.data);
				end else begin
					want_rsp = expected_rsps.pop_front();
					check_field("slot_address", want_rsp.slot_address,
						rsp_ch.data.slot_address);
					check_field("status", ADDR_W'(want_rsp.status),
						ADDR_W'(rsp_ch.data.status));
					check_field("owned", ADDR_W'(want_rsp.owned),
						ADDR_W'(rsp_ch.data.owned));
					check_field("in_use", ADDR_W'(want_rsp.in_use),
						ADDR_W'(rsp_ch.data.in_use));
					check_field("peak_in_use", ADDR_W'(want_rsp.peak_in_use),
						ADDR_W'(rsp_ch.data.peak_in_use));
					check_field("free_count", ADDR_W'(want_rsp.free_count),
						ADDR_W'(rsp_ch.data.free_count));
				end
			end
			if (req_ch.valid && req_ch.ready)
				expected_rsps.push_back(pool_step(req_ch.data));
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL fixed_slot_pool_allocator_top");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic [ADDR_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[ADDR_W-1:0];
	endfunction

	// keep the queue short so frees pick from nearly current live slots
	task automatic queue_req(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
		req_t item;
		item.req_type = op;
		item.address = addr;
		while (pending_reqs.size() >= 4)
			@(negedge clk);
		pending_reqs.push_back(item);
	endtask

	// every sent item answered and nothing in flight
	task automatic drain();
		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_BASE: pool_base = value;
			CFG_SIZE: pool_size = value[SIZE_CFG_W-1:0];
			default:  pool_count = value[CNT_CFG_W-1:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// new pool settings; slots out and the free list carry over
	task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [SIZE_CFG_W-1:0] size,
			input logic [CNT_CFG_W-1:0] count);
		drain();
		repeat (2) @(posedge clk);
		write_reg(CFG_BASE, base);
		write_reg(CFG_SIZE, {35'd0, size});
		write_reg(CFG_COUNT, {37'd0, count});
		// old handles may no longer be slots of the new pool
		live_slots.delete();
	endtask

	// one random item, weighted toward allocate/free of live slots
	task automatic random_req();
		int r;
		int sub;
		logic [ADDR_W-1:0] a;
		int unsigned cnt;
		r = $urandom_range(0, 99);
		sub = $urandom_range(0, 5);
		a = rand48();
		cnt = pool_slots();
		if (r < 40) begin
			queue_req(REQ_ALLOC, a);
		end else if (r < 64) begin
			if (live_slots.size() > 0)
				a = live_slots[$urandom_range(0, live_slots.size() - 1)];
			else if (cnt > 0)
				a = slot_at($urandom_range(0, cnt - 1));
			queue_req(REQ_FREE, a);
		end else if (r < 74 || r < 96) begin
			// broken frees and ownership queries share the odd addresses
			case (sub)
				0: a = '0;
				1: a = slot_at($urandom_range(0, cnt))
					+ $urandom_range(1, 32'(slot_bytes() - 1));
				2: a = pool_base - 1;
				3: a = slot_at(cnt + $urandom_range(0, 3));
				4: a = rand48();
				default: begin
					if (live_slots.size() > 0 && $urandom_range(0, 1) == 1)
						a = live_slots[$urandom_range(0, live_slots.size() - 1)];
					else
						a = slot_at($urandom_range(0, cnt));
				end
			endcase
			queue_req((r < 74) ? REQ_FREE : REQ_QUERY, a);
		end else begin
			queue_req(REQ_RESET, a);
		end
	endtask

	// pool settings per random phase: fixed corners first, then random
	task automatic pick_pool(input int p, output logic [ADDR_W-1:0] base,
			output logic [SIZE_CFG_W-1:0] size, output logic [CNT_CFG_W-1:0] count);
		base = rand48();
		size = SIZE_CFG_W'($urandom_range(0, 8191));
		count = ($urandom_range(0, 99) < 60) ? CNT_CFG_W'($urandom_range(1, 12))
			: CNT_CFG_W'($urandom_range(0, 2047));
		case (p)
			0: begin base = BASE_RST; size = SIZE_RST; count = 11'd4; end
			1: begin base = '0; size = '0; count = 11'd16; end
			2: begin base = 48'hFFFF_FFFF_A000; size = 13'd8191; count = 11'd1024; end
			3: begin base = 48'd1; size = 13'd17; count = 11'd2047; end
			4: begin size = 13'd4096; count = 11'd1; end
			5: count = '0;
			6: begin base = BASE_RST; size = 13'd16; count = COUNT_RST; end
			7: begin base = 48'hFFFF_FFFF_FFFF; size = 13'd16; count = 11'd8; end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	logic [ADDR_W-1:0]     ph_base;
	logic [SIZE_CFG_W-1:0] ph_size;
	logic [CNT_CFG_W-1:0]  ph_count;

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at the reset settings
		queue_req(REQ_QUERY, slot_at(0));            // first slot owned
		queue_req(REQ_ALLOC, rand48());              // slot 0
		queue_req(REQ_ALLOC, '0);                    // slot 1
		queue_req(REQ_FREE, slot_at(1));
		queue_req(REQ_FREE, '0);                     // null free
		queue_req(REQ_FREE, slot_at(0) + 4);         // misaligned
		queue_req(REQ_FREE, pool_base - 1);          // below the pool
		queue_req(REQ_FREE, slot_at(SLOTS));         // one past the end
		queue_req(REQ_QUERY, slot_at(SLOTS - 1));    // last slot owned
		queue_req(REQ_QUERY, {ADDR_W{1'b1}});
		queue_req(REQ_ALLOC, {ADDR_W{1'b1}});        // LIFO reuse of slot 1
		queue_req(REQ_FREE, slot_at(0));
		queue_req(REQ_FREE, slot_at(0));             // double free, not caught
		queue_req(REQ_ALLOC, '0);
		queue_req(REQ_ALLOC, '0);
		queue_req(REQ_RESET, {ADDR_W{1'b1}});        // peak is kept
		queue_req(REQ_FREE, slot_at(0));             // in_use stays at zero
		queue_req(REQ_ALLOC, '0);
		queue_req(REQ_QUERY, '0);

		// empty pool at base zero: exhausted, nothing owned, free of 0 is null
		set_pool('0, '0, '0);
		queue_req(REQ_ALLOC, '0);
		queue_req(REQ_QUERY, '0);
		queue_req(REQ_FREE, '0);

		// count above the slot limit, top size, slot 0 just below the address wrap
		set_pool(48'hFFFF_FFFF_FFF0, 13'd8191, 11'd2047);
		queue_req(REQ_ALLOC, '0);
		queue_req(REQ_QUERY, 48'hFFFF_FFFF_FFF0);

		// random phases, each with its own pool settings
		for (int p = 0; p < PHASES; p++) begin
			pick_pool(p, ph_base, ph_size, ph_count);
			set_pool(ph_base, ph_size, ph_count);
			calm_phase = (p % 4 == 2);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_req();
		end

		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("PASS fixed_slot_pool_allocator_top");
		else
			$display("FAIL fixed_slot_pool_allocator_top");
		$finish;
	end

endmodule

`default_nettype wire

/* fixed_slot_pool_allocator_top.f */
design/fspa_pkg.sv
design/fspa_req_if.sv
design/fspa_rsp_if.sv
design/fspa_div.sv
design/fspa_dp.sv
design/fspa_ctrl.sv
design/fixed_slot_pool_allocator_top.sv
tb/fixed_slot_pool_allocator_top_tb.sv
